>>> hw/rtl/lcd4_pkg.sv
// Shared types and constants for the 4-bit character LCD write sequencer.
// Used by the front end, the queue, the sequencer back end and the top level.
`timescale 1ns / 1ps

package lcd4_pkg;

  localparam int unsigned CMD_WIDTH    = 2;
  localparam int unsigned BYTE_WIDTH   = 8;
  localparam int unsigned NIBBLE_WIDTH = 4;
  localparam int unsigned CFG_WIDTH    = 16;
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam int unsigned IN_TDATA_WIDTH  = 16;
  localparam int unsigned IN_TUSER_WIDTH  = 2;
  localparam int unsigned OUT_TDATA_WIDTH = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NIDX_WIDTH  = 3;

  localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_INIT  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 2'd2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_INIT_DELAY   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PULSE_DELAY  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SETTLE_DELAY = 2'd2;

  localparam logic [CFG_WIDTH-1:0] INIT_DELAY_RESET   = 16'd6;
  localparam logic [CFG_WIDTH-1:0] PULSE_DELAY_RESET  = 16'd1;
  localparam logic [CFG_WIDTH-1:0] SETTLE_DELAY_RESET = 16'd5;

  localparam logic [NIDX_WIDTH-1:0] INIT_NIBBLES  = 3'd4;
  localparam logic [NIDX_WIDTH-1:0] WRITE_NIBBLES = 3'd2;

  localparam logic [NIBBLE_WIDTH-1:0] INIT_NIBBLE_WAKE = 4'h3;
  localparam logic [NIBBLE_WIDTH-1:0] INIT_NIBBLE_MODE = 4'h2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_INIT,
    KIND_WRITE
  } item_kind_t;

  typedef struct packed {
    item_kind_t            kind;
    logic [BYTE_WIDTH-1:0] data_byte;
    logic                  register_select;
  } queue_entry_t;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [CFG_WIDTH-1:0]     data;
  } cfg_write_t;

  function automatic logic [NIBBLE_WIDTH-1:0] init_nibble(input logic [1:0] idx);
    logic [NIBBLE_WIDTH-1:0] nib;
    nib = (idx == 2'd3) ? INIT_NIBBLE_MODE : INIT_NIBBLE_WAKE;
    return nib;
  endfunction

endpackage

>>> hw/rtl/lcd4_front.sv
// Input side of the LCD sequencer: accepts stream transactions and classifies
// each command into a queue entry. Depends on lcd4_pkg.
`timescale 1ns / 1ps

module lcd4_front (
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [lcd4_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,
  input  logic [lcd4_pkg::IN_TUSER_WIDTH-1:0]   s_tuser,
  input  logic                                  q_full,
  output logic                                  push,
  output lcd4_pkg::queue_entry_t                entry
);

  lcd4_pkg::item_kind_t kind;

  always_comb begin
    unique case (s_tuser)
      lcd4_pkg::CMD_INIT:  kind = lcd4_pkg::KIND_INIT;
      lcd4_pkg::CMD_WRITE: kind = lcd4_pkg::KIND_WRITE;
      default:             kind = lcd4_pkg::KIND_TICK;
    endcase
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  assign entry.kind            = kind;
  assign entry.data_byte       = s_tdata[lcd4_pkg::BYTE_WIDTH-1:0];
  assign entry.register_select = s_tdata[lcd4_pkg::BYTE_WIDTH];

endmodule

>>> hw/rtl/lcd4_queue.sv
// Short first-in first-out queue of classified items between the front end
// and the sequencer. Depends on lcd4_pkg.
`timescale 1ns / 1ps

module lcd4_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lcd4_pkg::queue_entry_t push_data,
  input  logic                   pop,
  output logic                   q_valid,
  output logic                   q_full,
  output lcd4_pkg::queue_entry_t q_data
);

  localparam int unsigned PTR_WIDTH = $clog2(lcd4_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_WIDTH = $clog2(lcd4_pkg::QUEUE_DEPTH + 1);

  lcd4_pkg::queue_entry_t entries [lcd4_pkg::QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr;
  logic [PTR_WIDTH-1:0] rd_ptr;
  logic [CNT_WIDTH-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CNT_WIDTH'(lcd4_pkg::QUEUE_DEPTH));
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/lcd4_back.sv
// Sequencer back end: holds the delay registers, steps the EN/RS/nibble
// state machine once per queued item and registers each result.
// Depends on lcd4_pkg.
`timescale 1ns / 1ps

module lcd4_back #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lcd4_pkg::cfg_write_t                 cfg,
  input  logic                                 q_valid,
  input  lcd4_pkg::queue_entry_t               q_data,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lcd4_pkg::OUT_TDATA_WIDTH-1:0] m_tdata
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  function automatic logic [TIMER_WIDTH-1:0] load_value(
    input logic [lcd4_pkg::CFG_WIDTH-1:0] value
  );
    logic [TIMER_WIDTH-1:0] v;
    v = TIMER_WIDTH'(value);
    return (v == '0) ? TIMER_WIDTH'(1) : v;
  endfunction

  logic [lcd4_pkg::CFG_WIDTH-1:0] init_delay_ticks;
  logic [lcd4_pkg::CFG_WIDTH-1:0] pulse_delay_ticks;
  logic [lcd4_pkg::CFG_WIDTH-1:0] settle_delay_ticks;

  phase_t                               phase, phase_next;
  logic [lcd4_pkg::NIDX_WIDTH-1:0]      nibble_index, nibble_index_next;
  logic [TIMER_WIDTH-1:0]               delay_count, delay_count_next;
  logic [lcd4_pkg::BYTE_WIDTH-1:0]      held_byte, held_byte_next;
  logic                                 init_mode, init_mode_next;
  logic                                 en_level, en_level_next;
  logic                                 rs_level, rs_level_next;
  logic [lcd4_pkg::NIBBLE_WIDTH-1:0]    bus_nibble, bus_nibble_next;
  logic                                 rejected_next;
  logic                                 m_tvalid_next;
  logic [lcd4_pkg::OUT_TDATA_WIDTH-1:0] m_tdata_next;

  logic                              busy;
  logic                              is_request;
  logic [TIMER_WIDTH-1:0]            count_dec;
  logic [lcd4_pkg::NIDX_WIDTH-1:0]   index_inc;
  logic [lcd4_pkg::NIDX_WIDTH-1:0]   nibble_limit;

  assign pop        = q_valid && (!m_tvalid || m_tready);
  assign busy       = (phase != PH_IDLE);
  assign is_request = (q_data.kind == lcd4_pkg::KIND_INIT) ||
                      (q_data.kind == lcd4_pkg::KIND_WRITE);
  assign count_dec  = (delay_count != '0) ? delay_count - 1'b1 : '0;
  assign index_inc  = nibble_index + 1'b1;
  assign nibble_limit = init_mode ? lcd4_pkg::INIT_NIBBLES : lcd4_pkg::WRITE_NIBBLES;

  always_comb begin
    phase_next        = phase;
    nibble_index_next = nibble_index;
    delay_count_next  = delay_count;
    held_byte_next    = held_byte;
    init_mode_next    = init_mode;
    en_level_next     = en_level;
    rs_level_next     = rs_level;
    bus_nibble_next   = bus_nibble;
    rejected_next     = 1'b0;

    if (is_request) begin
      if (busy) begin
        rejected_next = 1'b1;
      end else begin
        init_mode_next    = (q_data.kind == lcd4_pkg::KIND_INIT);
        held_byte_next    = q_data.data_byte;
        nibble_index_next = '0;
        en_level_next     = 1'b1;
        phase_next        = PH_HIGH;
        if (q_data.kind == lcd4_pkg::KIND_INIT) begin
          rs_level_next    = 1'b0;
          bus_nibble_next  = lcd4_pkg::init_nibble(2'd0);
          delay_count_next = load_value(init_delay_ticks);
        end else begin
          rs_level_next    = q_data.register_select;
          bus_nibble_next  = q_data.data_byte[7:4];
          delay_count_next = load_value(pulse_delay_ticks);
        end
      end
    end else if (busy) begin
      delay_count_next = count_dec;
      if (count_dec == '0) begin
        if (phase == PH_HIGH) begin
          en_level_next = 1'b0;
          phase_next    = PH_LOW;
          if (init_mode) begin
            delay_count_next = load_value(init_delay_ticks);
          end else if (nibble_index == '0) begin
            delay_count_next = load_value(pulse_delay_ticks);
          end else begin
            delay_count_next = load_value(settle_delay_ticks);
          end
        end else if (index_inc < nibble_limit) begin
          nibble_index_next = index_inc;
          en_level_next     = 1'b1;
          phase_next        = PH_HIGH;
          if (init_mode) begin
            bus_nibble_next  = lcd4_pkg::init_nibble(index_inc[1:0]);
            delay_count_next = load_value(init_delay_ticks);
          end else begin
            bus_nibble_next  = (index_inc == '0) ? held_byte[7:4] : held_byte[3:0];
            delay_count_next = load_value(pulse_delay_ticks);
          end
        end else begin
          phase_next        = PH_IDLE;
          nibble_index_next = '0;
          delay_count_next  = '0;
          en_level_next     = 1'b0;
        end
      end
    end

    m_tdata_next = {rejected_next, (phase_next != PH_IDLE), bus_nibble_next,
                    rs_level_next, en_level_next};

    if (pop) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_delay_ticks   <= lcd4_pkg::INIT_DELAY_RESET;
      pulse_delay_ticks  <= lcd4_pkg::PULSE_DELAY_RESET;
      settle_delay_ticks <= lcd4_pkg::SETTLE_DELAY_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        lcd4_pkg::REG_INIT_DELAY:   init_delay_ticks   <= cfg.data;
        lcd4_pkg::REG_PULSE_DELAY:  pulse_delay_ticks  <= cfg.data;
        lcd4_pkg::REG_SETTLE_DELAY: settle_delay_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      nibble_index <= '0;
      delay_count  <= '0;
      held_byte    <= '0;
      init_mode    <= 1'b0;
      en_level     <= 1'b0;
      rs_level     <= 1'b0;
      bus_nibble   <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        nibble_index <= nibble_index_next;
        delay_count  <= delay_count_next;
        held_byte    <= held_byte_next;
        init_mode    <= init_mode_next;
        en_level     <= en_level_next;
        rs_level     <= rs_level_next;
        bus_nibble   <= bus_nibble_next;
        m_tdata      <= m_tdata_next;
      end
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

>>> hw/rtl/lcd_4bit_nibble_write_sequencer.sv
// Top level of the 4-bit character LCD write sequencer.
// Each accepted transaction passes through the queue and a result register.
// Throughput: one transaction per cycle while m_tready does not hold the output.
// A four-entry queue decouples input acceptance from output back-pressure.
// Reset clears the queue and the sequencer to idle with all pins low and loads
// the delay registers with 6, 1 and 5 ticks.
`timescale 1ns / 1ps

module lcd_4bit_nibble_write_sequencer #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata fields from bit 0: data_byte[7:0], register_select[8], zero fill.
  input  logic [lcd4_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,
  // s_tuser fields from bit 0: cmd[1:0].
  input  logic [lcd4_pkg::IN_TUSER_WIDTH-1:0]    s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata fields from bit 0: en_line[0], rs_line[1], data_nibble[5:2],
  // busy_res[6], rejected[7].
  output logic [lcd4_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata,
  input  logic                                   cfg_we,
  input  logic [lcd4_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [lcd4_pkg::CFG_WIDTH-1:0]         cfg_data
);

  logic                   push;
  logic                   pop;
  logic                   q_valid;
  logic                   q_full;
  lcd4_pkg::queue_entry_t push_data;
  lcd4_pkg::queue_entry_t q_data;
  lcd4_pkg::cfg_write_t   cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  lcd4_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_data)
  );

  lcd4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  lcd4_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
